### sv/smac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smac_pkg: shared types and helpers of the sliding mode angle controller
// Field widths, register indexes, sequencer states and the wide saturation
// helpers used by the core and its serial multiplier.
// ----------------------------------------------------------------------------
package smac_pkg;

  localparam int AngleW = 32;   // Q16.16 input and output words
  localparam int GainW  = 31;   // unsigned Q15.16 registers
  localparam int WideW  = 49;   // signed intermediates, +-(2^48 - 1)
  localparam int MagW   = 48;   // magnitude of an intermediate
  localparam int FracW  = 16;   // fraction bits
  localparam int CfgIdxW = 3;

  localparam logic [GainW-1:0] SurfaceSlopeRst  = 31'd1310720;
  localparam logic [GainW-1:0] ReachingGainRst  = 31'd7864320;
  localparam logic [GainW-1:0] ErrorDeadbandRst = 31'd66;
  localparam logic [GainW-1:0] DriveLimitRst    = 31'd1638400000;
  localparam logic [GainW-1:0] InertiaGainRst   = 31'd52429;
  localparam logic [GainW-1:0] SwitchingGainRst = 31'd32768;

  localparam logic signed [WideW:0]   SumLimPos = 50'sd281474976710655;
  localparam logic signed [WideW:0]   SumLimNeg = -50'sd281474976710655;
  localparam logic signed [WideW-1:0] OneQ16    = 49'sd65536;
  localparam logic signed [WideW-1:0] MinusOneQ16 = -49'sd65536;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SURFACE_SLOPE  = 3'd0,
    CFG_REACHING_GAIN  = 3'd1,
    CFG_ERROR_DEADBAND = 3'd2,
    CFG_DRIVE_LIMIT    = 3'd3,
    CFG_INERTIA_GAIN   = 3'd4,
    CFG_SWITCHING_GAIN = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_CHECK,
    ST_LOAD,
    ST_MUL,
    ST_COMB,
    ST_DONE
  } state_e;

  // Products in the order the control law needs them
  typedef enum logic [2:0] {
    OP_SURF,    // C * error
    OP_DAMP,    // C * (velocity - rate)
    OP_SWITCH,  // epsilon * sat(s)
    OP_REACH,   // K * s
    OP_SCALE    // J * inner
  } op_e;

  typedef struct packed {
    logic             start;
    logic [GainW-1:0] gain;
    logic [MagW-1:0]  mag;
  } mul_req_t;

  typedef struct packed {
    logic            done;
    logic [MagW-1:0] prod;
  } mul_rsp_t;

  // Saturate a sum or difference to +-(2^48 - 1)
  function automatic logic signed [WideW-1:0] clampw(input logic signed [WideW:0] v);
    logic signed [WideW-1:0] r;
    if (v > SumLimPos) begin
      r = SumLimPos[WideW-1:0];
    end else if (v < SumLimNeg) begin
      r = SumLimNeg[WideW-1:0];
    end else begin
      r = v[WideW-1:0];
    end
    return r;
  endfunction

  // Boundary layer: clamp s to +-1.0
  function automatic logic signed [WideW-1:0] bsat(input logic signed [WideW-1:0] s);
    logic signed [WideW-1:0] r;
    if (s > OneQ16) begin
      r = OneQ16;
    end else if (s < MinusOneQ16) begin
      r = MinusOneQ16;
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

### sv/sliding_mode_angle_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_mode_angle_controller_core: sliding mode angle controller
// Deadband check, reference differencing, sliding surface with a boundary
// layer and a clamped drive, all in Q16.16 with 49-bit saturated intermediates.
// ----------------------------------------------------------------------------
//
//  channel   direction  tdata (low bit up)                        tuser
//  s_*       in         measured_angle, measured_rate, target     -
//  m_*       out        drive                                     in_deadband
//  cfg_*     in         write enable, register index, 31-bit data -
//
// One word is taken at a time: s_tready_o is high only while the sequencer is
// idle. Outside the deadband a word passes from accept to the result register
// through two differencing steps, five products and one finishing step; the
// bit-serial multiplier behind each product takes one gain bit per cycle.
// Inside the deadband the check skips the products and writes a zero drive.
// A result waiting on m_tready_i holds only the finishing step; the next word
// is accepted as soon as the result sits in the output register.
// Reset restores the register defaults and clears the reference history.
//
module sliding_mode_angle_controller_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // stream in: [31:0] measured_angle, [63:32] measured_rate, [95:64] target_angle
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [3*smac_pkg::AngleW-1:0]  s_tdata_i,
  // stream out: [31:0] drive
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [smac_pkg::AngleW-1:0]    m_tdata_o,
  // [0] in_deadband
  output logic [0:0]                     m_tuser_o,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [smac_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [smac_pkg::GainW-1:0]     cfg_data_i
);

  localparam int AW = smac_pkg::AngleW;
  localparam int WW = smac_pkg::WideW;
  localparam int GW = smac_pkg::GainW;

  // Configuration registers
  logic [GW-1:0] slope_q, reach_q, deadband_q, drive_limit_q, inertia_q, switch_q;

  // Sequencer
  smac_pkg::state_e state_q, state_d;
  smac_pkg::op_e    op_q, op_d;

  // Working registers
  logic signed [AW-1:0] ang_q, ang_d, vel_q, vel_d, tgt_q, tgt_d;
  logic signed [AW:0]   err_q, err_d, rate_q, rate_d;
  logic signed [AW+1:0] accel_q, accel_d, vd_q, vd_d;
  logic signed [WW-1:0] s_q, s_d, inner_q, inner_d, prod_q, prod_d;
  logic                 neg_q, neg_d;
  logic signed [AW-1:0] res_drive_q, res_drive_d;
  logic                 res_db_q, res_db_d;

  // Reference history
  logic signed [AW-1:0] prev_tgt_q, prev_tgt_d;
  logic signed [AW:0]   tgt_rate_q, tgt_rate_d;

  // Output register
  logic                 out_valid_q, out_valid_d;
  logic [AW-1:0]        out_drive_q, out_drive_d;
  logic                 out_db_q, out_db_d;

  // Multiplier link and combinational helpers
  smac_pkg::mul_req_t   mul_req;
  smac_pkg::mul_rsp_t   mul_rsp;
  logic signed [WW-1:0] operand, operand_neg, prod_mag, lim_pos, lim_neg;
  logic signed [WW:0]   comb_sum;
  logic [AW:0]          abs_err;
  logic [GW-1:0]        gain_sel;

  smac_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // Operand and gain for the current product
  always_comb begin
    case (op_q)
      smac_pkg::OP_SURF: begin
        operand  = {{(WW-AW-1){err_q[AW]}}, err_q};
        gain_sel = slope_q;
      end
      smac_pkg::OP_DAMP: begin
        operand  = {{(WW-AW-2){vd_q[AW+1]}}, vd_q};
        gain_sel = slope_q;
      end
      smac_pkg::OP_SWITCH: begin
        operand  = smac_pkg::bsat(s_q);
        gain_sel = switch_q;
      end
      smac_pkg::OP_REACH: begin
        operand  = s_q;
        gain_sel = reach_q;
      end
      smac_pkg::OP_SCALE: begin
        operand  = inner_q;
        gain_sel = inertia_q;
      end
      default: begin
        operand  = '0;
        gain_sel = '0;
      end
    endcase
  end

  assign operand_neg = -operand;
  assign prod_mag    = {1'b0, mul_rsp.prod};
  assign lim_pos     = {{(WW-GW){1'b0}}, drive_limit_q};
  assign lim_neg     = -lim_pos;
  assign abs_err     = err_q[AW] ? -err_q : err_q;

  // Sum for the step that follows each product
  always_comb begin
    case (op_q)
      smac_pkg::OP_SURF: comb_sum = {prod_q[WW-1], prod_q}
                                    + {{(WW-AW-1){vd_q[AW+1]}}, vd_q};
      smac_pkg::OP_DAMP: comb_sum = {{(WW-AW-1){accel_q[AW+1]}}, accel_q}
                                    - {prod_q[WW-1], prod_q};
      default:           comb_sum = {inner_q[WW-1], inner_q} - {prod_q[WW-1], prod_q};
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    ang_d       = ang_q;
    vel_d       = vel_q;
    tgt_d       = tgt_q;
    err_d       = err_q;
    rate_d      = rate_q;
    accel_d     = accel_q;
    vd_d        = vd_q;
    s_d         = s_q;
    inner_d     = inner_q;
    prod_d      = prod_q;
    neg_d       = neg_q;
    res_drive_d = res_drive_q;
    res_db_d    = res_db_q;
    prev_tgt_d  = prev_tgt_q;
    tgt_rate_d  = tgt_rate_q;
    out_valid_d = out_valid_q;
    out_drive_d = out_drive_q;
    out_db_d    = out_db_q;
    mul_req     = '0;
    s_tready_o  = 1'b0;

    // drop the result once the sink takes it
    if (out_valid_q && m_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      smac_pkg::ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          ang_d   = s_tdata_i[AW-1:0];
          vel_d   = s_tdata_i[2*AW-1:AW];
          tgt_d   = s_tdata_i[3*AW-1:2*AW];
          state_d = smac_pkg::ST_DIFF;
        end
      end
      smac_pkg::ST_DIFF: begin
        err_d   = {ang_q[AW-1], ang_q} - {tgt_q[AW-1], tgt_q};
        rate_d  = {tgt_q[AW-1], tgt_q} - {prev_tgt_q[AW-1], prev_tgt_q};
        state_d = smac_pkg::ST_CHECK;
      end
      smac_pkg::ST_CHECK: begin
        if (abs_err < {2'b00, deadband_q}) begin
          // inside the deadband: zero drive, keep the history
          res_drive_d = '0;
          res_db_d    = 1'b1;
          state_d     = smac_pkg::ST_DONE;
        end else begin
          accel_d    = {rate_q[AW], rate_q} - {tgt_rate_q[AW], tgt_rate_q};
          vd_d       = {{2{vel_q[AW-1]}}, vel_q} - {rate_q[AW], rate_q};
          prev_tgt_d = tgt_q;
          tgt_rate_d = rate_q;
          op_d       = smac_pkg::OP_SURF;
          state_d    = smac_pkg::ST_LOAD;
        end
      end
      smac_pkg::ST_LOAD: begin
        // hand the magnitude to the multiplier, keep the sign here
        mul_req.start = 1'b1;
        mul_req.gain  = gain_sel;
        mul_req.mag   = operand[WW-1] ? operand_neg[WW-2:0] : operand[WW-2:0];
        neg_d         = operand[WW-1];
        state_d       = smac_pkg::ST_MUL;
      end
      smac_pkg::ST_MUL: begin
        if (mul_rsp.done) begin
          prod_d  = neg_q ? -prod_mag : prod_mag;
          state_d = smac_pkg::ST_COMB;
        end
      end
      smac_pkg::ST_COMB: begin
        state_d = smac_pkg::ST_LOAD;
        case (op_q)
          smac_pkg::OP_SURF: begin
            s_d  = smac_pkg::clampw(comb_sum);
            op_d = smac_pkg::OP_DAMP;
          end
          smac_pkg::OP_DAMP: begin
            inner_d = smac_pkg::clampw(comb_sum);
            op_d    = smac_pkg::OP_SWITCH;
          end
          smac_pkg::OP_SWITCH: begin
            inner_d = smac_pkg::clampw(comb_sum);
            op_d    = smac_pkg::OP_REACH;
          end
          smac_pkg::OP_REACH: begin
            inner_d = smac_pkg::clampw(comb_sum);
            op_d    = smac_pkg::OP_SCALE;
          end
          default: begin
            // final drive, clamped to the limit
            if (prod_q > lim_pos) begin
              res_drive_d = lim_pos[AW-1:0];
            end else if (prod_q < lim_neg) begin
              res_drive_d = lim_neg[AW-1:0];
            end else begin
              res_drive_d = prod_q[AW-1:0];
            end
            res_db_d = 1'b0;
            state_d  = smac_pkg::ST_DONE;
          end
        endcase
      end
      smac_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || m_tready_i) begin
          out_valid_d = 1'b1;
          out_drive_d = res_drive_q;
          out_db_d    = res_db_q;
          state_d     = smac_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = smac_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= smac_pkg::ST_IDLE;
      op_q          <= smac_pkg::OP_SURF;
      out_valid_q   <= 1'b0;
      prev_tgt_q    <= '0;
      tgt_rate_q    <= '0;
      slope_q       <= smac_pkg::SurfaceSlopeRst;
      reach_q       <= smac_pkg::ReachingGainRst;
      deadband_q    <= smac_pkg::ErrorDeadbandRst;
      drive_limit_q <= smac_pkg::DriveLimitRst;
      inertia_q     <= smac_pkg::InertiaGainRst;
      switch_q      <= smac_pkg::SwitchingGainRst;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
      prev_tgt_q  <= prev_tgt_d;
      tgt_rate_q  <= tgt_rate_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          smac_pkg::CFG_SURFACE_SLOPE:  slope_q       <= cfg_data_i;
          smac_pkg::CFG_REACHING_GAIN:  reach_q       <= cfg_data_i;
          smac_pkg::CFG_ERROR_DEADBAND: deadband_q    <= cfg_data_i;
          smac_pkg::CFG_DRIVE_LIMIT:    drive_limit_q <= cfg_data_i;
          smac_pkg::CFG_INERTIA_GAIN:   inertia_q     <= cfg_data_i;
          smac_pkg::CFG_SWITCHING_GAIN: switch_q      <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q       <= ang_d;
    vel_q       <= vel_d;
    tgt_q       <= tgt_d;
    err_q       <= err_d;
    rate_q      <= rate_d;
    accel_q     <= accel_d;
    vd_q        <= vd_d;
    s_q         <= s_d;
    inner_q     <= inner_d;
    prod_q      <= prod_d;
    neg_q       <= neg_d;
    res_drive_q <= res_drive_d;
    res_db_q    <= res_db_d;
    out_drive_q <= out_drive_d;
    out_db_q    <= out_db_d;
  end

  assign m_tvalid_o   = out_valid_q;
  assign m_tdata_o    = out_drive_q;
  assign m_tuser_o[0] = out_db_q;

`ifndef SYNTHESIS
  // An accepted word always starts the differencing step
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> state_q == smac_pkg::ST_DIFF)
    else $error("accepted word did not start the sequencer");

  // The multiplier finishes only while the sequencer waits on it
  a_mul_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> state_q == smac_pkg::ST_MUL)
    else $error("multiplier result outside the multiply step");

  // The reference history moves only out of the deadband check
  a_history_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != smac_pkg::ST_CHECK |=> $stable(prev_tgt_q) && $stable(tgt_rate_q))
    else $error("reference history changed outside the deadband check");

  // A shown drive stays within the configured limit
  a_drive_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> ($signed(m_tdata_o) <= $signed({1'b0, drive_limit_q}))
                && ($signed(m_tdata_o) >= -$signed({1'b0, drive_limit_q})))
    else $error("drive beyond the limit");
`endif

endmodule

### sv/smac_serial_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smac_serial_mul: bit-serial gain by magnitude multiplier
// Walks the gain one bit per cycle, LSB first, with a shift-right accumulator.
// Returns floor(gain * mag / 2^16) saturated to 2^48 - 1.
// ----------------------------------------------------------------------------
module smac_serial_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smac_pkg::mul_req_t  req_i,
  output smac_pkg::mul_rsp_t  rsp_o
);

  localparam int CntW = $clog2(smac_pkg::GainW + 1);
  localparam int QW   = smac_pkg::MagW + smac_pkg::GainW - smac_pkg::FracW;

  logic [smac_pkg::MagW-1:0]  acc_q, acc_d;
  logic [smac_pkg::MagW-1:0]  mag_q, mag_d;
  logic [smac_pkg::GainW-1:0] low_q, low_d;
  logic [smac_pkg::GainW-1:0] gsh_q, gsh_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [smac_pkg::MagW:0]    sum;
  logic [QW-1:0]              quot;

  always_comb begin
    acc_d  = acc_q;
    mag_d  = mag_q;
    low_d  = low_q;
    gsh_d  = gsh_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    sum    = {1'b0, acc_q} + (gsh_q[0] ? {1'b0, mag_q} : '0);
    if (req_i.start) begin
      acc_d  = '0;
      low_d  = '0;
      mag_d  = req_i.mag;
      gsh_d  = req_i.gain;
      cnt_d  = CntW'(smac_pkg::GainW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // add the partial product, shift one product bit out to the low word
      acc_d = sum[smac_pkg::MagW:1];
      low_d = {sum[0], low_q[smac_pkg::GainW-1:1]};
      gsh_d = {1'b0, gsh_q[smac_pkg::GainW-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mag_q <= mag_d;
    low_q <= low_d;
    gsh_q <= gsh_d;
  end

  assign quot = {acc_q, low_q[smac_pkg::GainW-1:smac_pkg::FracW]};

  assign rsp_o.done = done_q;
  assign rsp_o.prod = (|quot[QW-1:smac_pkg::MagW]) ? '1 : quot[smac_pkg::MagW-1:0];

endmodule
